// ===== design/gcd_pkg.sv =====
`default_nettype none
package gcd_pkg;

  localparam int GUARD_LEN   = 5;
  localparam int GUARD_W     = 40;
  localparam int MATCH_W     = $clog2(GUARD_LEN + 1);
  localparam int GUARD_EXT_W = (8 * GUARD_LEN > GUARD_W) ? 8 * GUARD_LEN : GUARD_W;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 40'h57414C444F;

  typedef logic [GUARD_W-1:0] guard_t;
  typedef logic [MATCH_W-1:0] match_t;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_LEN     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  // Guard byte i, first expected byte first; bytes past the register read as zero.
  function automatic logic [7:0] guard_byte(input guard_t g, input int i);
    logic [GUARD_EXT_W-1:0] ext;
    ext = GUARD_EXT_W'(g);
    return 8'(ext >> (8 * (GUARD_LEN - 1 - i)));
  endfunction

endpackage
`default_nettype wire

// ===== design/gcd_guard_match.sv =====
`default_nettype none
// Next guard match count: longest suffix of (matched prefix, new byte) that is
// again a guard prefix. All candidate lengths are checked in parallel.
module gcd_guard_match (
  input  wire gcd_pkg::guard_t guard,
  input  wire gcd_pkg::match_t matched,
  input  wire logic [7:0]      rx_byte,
  output gcd_pkg::match_t      next_matched
);
  import gcd_pkg::*;

  always_comb begin
    logic ok;
    int   m;
    m = int'(matched);
    next_matched = '0;
    for (int k = 1; k <= GUARD_LEN; k++) begin
      ok = (k <= m + 1) && (rx_byte == guard_byte(guard, k - 1));
      for (int j = 0; j < GUARD_LEN - 1; j++) begin
        if (j < k - 1 && k <= m + 1) begin
          if (guard_byte(guard, j + m + 1 - k) != guard_byte(guard, j)) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        next_matched = MATCH_W'(k);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/guarded_command_deframer_unit.sv =====
`default_nettype none
// Guarded command deframer.
// in_*  : one received serial byte per word (in_tdata = rx_byte).
// out_* : one result word per payload byte, or one empty word for a
//         zero-length command. out_tdata = {data_byte, cmd_type}, out_tuser =
//         has_data, out_tlast marks the final word of a command.
// cfg_* : writes the 40-bit guard word; write only while the block is idle.
// Frame: guard bytes, type byte, length byte, then length payload bytes.
// A byte accepted into the input register is parsed when it advances, and its
// result (if any) is loaded into the output register and shown from then on.
// Throughput: one byte per cycle while the receiver does not stall, as the
// guard compare and state update between the two registers are combinational.
// Reset (rst_n low, synchronous): hunts for the guard from scratch, guard
// word back to its default, no output word pending.
// Receiver stall: the output register holds its word; the input register
// then holds one byte and in_tready drops until out_tready returns.
module guarded_command_deframer_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,  // [7:0] cmd_type, [15:8] data_byte
  output logic                   out_tuser,  // [0] has_data
  output logic                   out_tlast,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire gcd_pkg::guard_t   cfg_data
);
  import gcd_pkg::*;

  guard_t     guard_r;
  phase_t     phase_r, phase_nxt;
  match_t     matched_r, matched_nxt, match_calc;
  logic [7:0] held_type_r, held_type_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       advance;

  // output register
  logic       out_valid_r;
  logic [7:0] out_type_r, out_data_r;
  logic       out_has_r, out_last_r;

  // parse results for the byte in the input register
  logic       emit;
  logic [7:0] emit_data;
  logic       emit_has, emit_last;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r <= GUARD_RESET;
    end else if (cfg_valid) begin
      guard_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  gcd_guard_match u_match (
    .guard        (guard_r),
    .matched      (matched_r),
    .rx_byte      (s1_byte_r),
    .next_matched (match_calc)
  );

  always_comb begin
    phase_nxt      = phase_r;
    matched_nxt    = matched_r;
    held_type_nxt  = held_type_r;
    bytes_left_nxt = bytes_left_r;
    emit           = 1'b0;
    emit_data      = 8'd0;
    emit_has       = 1'b0;
    emit_last      = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (match_calc == MATCH_W'(GUARD_LEN)) begin
          matched_nxt = '0;
          phase_nxt   = PH_TYPE;
        end else begin
          matched_nxt = match_calc;
        end
      end
      PH_TYPE: begin
        held_type_nxt = s1_byte_r;
        phase_nxt     = PH_LEN;
      end
      PH_LEN: begin
        if (s1_byte_r == 8'd0) begin
          // empty command: one data-less last word
          emit           = 1'b1;
          emit_last      = 1'b1;
          phase_nxt      = PH_HUNT;
          matched_nxt    = '0;
          bytes_left_nxt = 8'd0;
        end else begin
          bytes_left_nxt = s1_byte_r;
          phase_nxt      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left_r != 8'd0) begin
          bytes_left_nxt = bytes_left_r - 8'd1;
        end
        emit      = 1'b1;
        emit_data = s1_byte_r;
        emit_has  = 1'b1;
        emit_last = (bytes_left_nxt == 8'd0);
        if (bytes_left_nxt == 8'd0) begin
          phase_nxt   = PH_HUNT;
          matched_nxt = '0;
        end
      end
      default: begin
        phase_nxt   = PH_HUNT;
        matched_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      matched_r    <= '0;
      held_type_r  <= 8'd0;
      bytes_left_r <= 8'd0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      matched_r    <= matched_nxt;
      held_type_r  <= held_type_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_type_r <= held_type_r;
      out_data_r <= emit_data;
      out_has_r  <= emit_has;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r, out_type_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== dv/tb_guarded_command_deframer_unit.sv =====
`timescale 1ns / 1ps
module tb_guarded_command_deframer_unit;
  import gcd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  // Margin for the last accepted byte to be parsed and its word to leave.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 330;

  // One decoded command word as it leaves the block.
  typedef struct packed {
    logic [7:0] cmd_type;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } cmd_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] cmd_type, [15:8] data_byte
  logic        out_tuser;        // [0] has_data
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  guard_t      cfg_data = '0;

  guarded_command_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stimulus and scoreboard storage.
  logic [7:0]  rx_bytes_q[$];     // bytes waiting to be sent
  cmd_word_t   cmd_words_q[$];    // decoded words still owed by the block
  int unsigned bytes_pushed = 0;
  int unsigned bytes_issued = 0;
  int unsigned bytes_taken = 0;
  int unsigned words_seen = 0;
  int unsigned guard_writes = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  guard_t      stim_guard = GUARD_RESET;  // guard the generator frames with

  // Deframer shadow state.
  guard_t      model_guard = GUARD_RESET;
  phase_t      cur_phase = PH_HUNT;
  int          guard_hits = 0;
  logic [7:0]  cur_type = '0;
  int          payload_left = 0;

  function automatic logic [7:0] guard_at(input guard_t g, input int i);
    logic [63:0] ext;
    ext = 64'(g);
    return ext[8*(GUARD_LEN-1-i) +: 8];
  endfunction

  // Longest guard prefix that ends the matched bytes plus the new one.
  function automatic int next_guard_match(input int m, input logic [7:0] b);
    logic [7:0] seq [0:GUARD_LEN];
    int n;
    bit ok;
    n = m + 1;
    for (int i = 0; i < m; i++) seq[i] = guard_at(model_guard, i);
    seq[m] = b;
    for (int k = n; k > 0; k--) begin
      if (k <= GUARD_LEN) begin
        ok = 1'b1;
        for (int i = 0; i < k; i++)
          if (seq[n-k+i] != guard_at(model_guard, i)) ok = 1'b0;
        if (ok) return k;
      end
    end
    return 0;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    cmd_word_t w;
    int m;
    case (cur_phase)
      PH_HUNT: begin
        m = (guard_hits >= GUARD_LEN) ? 0 : guard_hits;
        m = next_guard_match(m, b);
        if (m >= GUARD_LEN) begin
          guard_hits = 0;
          cur_phase = PH_TYPE;
        end else begin
          guard_hits = m;
        end
      end
      PH_TYPE: begin
        cur_type = b;
        cur_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          // empty command: one word, no data, marked last
          w = '{cmd_type: cur_type, data_byte: 8'd0, has_data: 1'b0, last: 1'b1};
          cmd_words_q.push_back(w);
          cur_phase = PH_HUNT;
          guard_hits = 0;
          payload_left = 0;
        end else begin
          payload_left = b;
          cur_phase = PH_PAYLOAD;
        end
      end
      default: begin
        if (payload_left > 0) payload_left--;
        w = '{cmd_type: cur_type, data_byte: b, has_data: 1'b1,
              last: (payload_left == 0)};
        cmd_words_q.push_back(w);
        if (payload_left == 0) begin
          cur_phase = PH_HUNT;
          guard_hits = 0;
        end
      end
    endcase
  endfunction

  // Input driver: holds a word until taken, idles at random otherwise.
  always @(posedge clk) begin : rx_driver
    bit holding;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      holding = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        parse_rx_byte(in_tdata);
        bytes_taken++;
      end
      if (!holding) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= rx_bytes_q.pop_front();
          in_tvalid <= 1'b1;
          bytes_issued++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure, field-by-field compare.
  always @(posedge clk) begin : cmd_monitor
    cmd_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (cmd_words_q.size() == 0) begin
          $error("unexpected word: tdata=%h tuser=%b tlast=%b",
                 out_tdata, out_tuser, out_tlast);
          fail_cnt++;
        end else begin
          want = cmd_words_q.pop_front();
          if (out_tdata[7:0] !== want.cmd_type) begin
            $error("cmd_type: expected %h, got %h", want.cmd_type, out_tdata[7:0]);
            fail_cnt++;
          end
          if (out_tdata[15:8] !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, out_tdata[15:8]);
            fail_cnt++;
          end
          if (out_tuser !== want.has_data) begin
            $error("has_data: expected %b, got %b", want.has_data, out_tuser);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            fail_cnt++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("cycle limit hit: %0d words still owed", cmd_words_q.size());
      $display("tb_guarded_command_deframer_unit: FAIL");
      $finish;
    end
  end

  // Stimulus helpers.
  function automatic void push_rx(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_pushed++;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_guard_prefix(input int k);
    for (int i = 0; i < k; i++) push_rx(guard_at(stim_guard, i));
  endfunction

  function automatic void push_frame(input logic [7:0] ctype, input int len);
    push_guard_prefix(GUARD_LEN);
    push_rx(ctype);
    push_rx(8'(len));
    for (int i = 0; i < len; i++) push_rx(rand_byte());
  endfunction

  // Mostly short payloads, now and then a long one.
  function automatic int rand_len();
    if ($urandom_range(99) < 2) return $urandom_range(255, 32);
    return $urandom_range(6, 0);
  endfunction

  function automatic void add_random_chunk();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 60) begin
      push_frame(rand_byte(), rand_len());
    end else if (r < 75) begin
      // line noise
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) push_rx(8'($urandom));
    end else if (r < 88) begin
      // guard cut short by a stray byte
      push_guard_prefix($urandom_range(GUARD_LEN - 1, 1));
      push_rx(8'($urandom));
    end else begin
      // partial guard running straight into a full one
      push_guard_prefix($urandom_range(GUARD_LEN - 1, 1));
      push_frame(rand_byte(), rand_len());
    end
  endfunction

  task automatic wait_idle();
    while (rx_bytes_q.size() != 0 || bytes_issued != bytes_taken ||
           cmd_words_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_guard(input guard_t g);
    @(posedge clk);
    cfg_data  <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    model_guard = g;
    stim_guard  = g;
    guard_writes++;
  endtask

  initial begin : stimulus
    guard_t phase_guard [4];
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    int unsigned start;

    phase_guard[0] = guard_t'({$urandom, $urandom});
    phase_guard[1] = '0;
    phase_guard[2] = 40'h4141414142;   // self-overlapping guard
    phase_guard[3] = GUARD_RESET;
    idle_tab  = '{0, 84, 0, 12};
    stall_tab = '{0, 0, 84, 12};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default guard, empty command with type 0.
    push_frame(8'h00, 0);
    // Guard restart: two guard bytes then the guard again; one-byte max payload.
    push_guard_prefix(2);
    push_guard_prefix(GUARD_LEN);
    push_rx(8'hFF);
    push_rx(8'h01);
    push_rx(8'hFF);
    // Partial match left standing across a guard rewrite.
    push_guard_prefix(2);
    wait_idle();
    write_guard(40'hFFFFFFFFFF);
    push_guard_prefix(GUARD_LEN - 2);
    push_rx(8'h5A);
    push_rx(8'h02);
    push_rx(8'h00);
    push_rx(8'h80);

    // Random phases, each under its own guard and idle pattern.
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_guard(phase_guard[p]);
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      if (p == 0) push_frame(rand_byte(), 255);
      start = bytes_pushed;
      while (bytes_pushed - start < PHASE_BYTES) add_random_chunk();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d rx bytes, %0d command words checked, %0d guard writes",
             bytes_taken, words_seen, guard_writes);
    $display("phases: no idling, sender gaps, receiver stalls, both mixed");
    if (fail_cnt == 0 && cmd_words_q.size() == 0) begin
      $display("tb_guarded_command_deframer_unit: PASS");
    end else begin
      $display("tb_guarded_command_deframer_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gcd_pkg.sv
design/gcd_guard_match.sv
design/guarded_command_deframer_unit.sv
dv/tb_guarded_command_deframer_unit.sv
